// ===== design/sorted_edge_region_merge_assert.svh =====
// ---------------------------------------------------------------------------
// Sorted edge region merge assertion macros
// Implication checks on the local clk, masked while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SORTED_EDGE_REGION_MERGE_ASSERT_SVH
`define SORTED_EDGE_REGION_MERGE_ASSERT_SVH

// Same-cycle implication
`define SERM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SERM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/serm_pkg.sv =====
// ---------------------------------------------------------------------------
// serm_pkg
// Shared widths, constants and divider interface types.
// ---------------------------------------------------------------------------
package serm_pkg;

  localparam int NUM_REGIONS = 4096;
  localparam int ID_W        = $clog2(NUM_REGIONS);
  localparam int REGION_W    = 12;
  localparam int WGT_W       = 16;
  localparam int SIZE_W      = 13;
  localparam int THR_W       = 24;
  localparam int CFG_IDX_W   = 2;
  localparam int DIV_CNT_W   = $clog2(THR_W);

  localparam logic [SIZE_W-1:0] SIZE_MAX = '1;
  localparam logic [THR_W-1:0]  THR_MAX  = '1;
  localparam logic [THR_W-1:0]  K_RESET  = 24'd76800;

  localparam logic [CFG_IDX_W-1:0] CFG_PASS_MODE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MERGE_K   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIZE  = 2'd2;

  typedef struct packed {
    logic              start;
    logic [THR_W-1:0]  dividend;
    logic [SIZE_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [THR_W-1:0] quotient;
  } div_rsp_t;

endpackage

// ===== design/sorted_edge_region_merge.sv =====
// ---------------------------------------------------------------------------
// sorted_edge_region_merge
// Union-find over region ids with path-halving finds, size-ranked unions and
// per-root merge thresholds, held in three single-read-port memories.
// ---------------------------------------------------------------------------
// Flow: each find walks parent hops with halving, then root detection, lookup
//   of size and threshold and the decision follow; an edge that merges also
//   waits for the serial k / size.
// Throughput: one edge at a time; the parent memory read port paces the finds.
// Reset: synchronous active low; a clearing pass then initializes all three
//   tables while no edge is accepted.
`include "sorted_edge_region_merge_assert.svh"

module sorted_edge_region_merge (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [serm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [serm_pkg::THR_W-1:0]         cfg_wdata,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [serm_pkg::REGION_W-1:0]      in_region_a,
  input  logic [serm_pkg::REGION_W-1:0]      in_region_b,
  input  logic [serm_pkg::WGT_W-1:0]         in_edge_weight,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_merged,
  output logic                               out_inner_edge,
  output logic                               out_kept_edge,
  output logic [serm_pkg::REGION_W-1:0]      out_root_a,
  output logic [serm_pkg::REGION_W-1:0]      out_root_b
);
  import serm_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_FIND_P, S_FIND_G, S_RD_A, S_RD_B, S_EVAL, S_DIV, S_DONE
  } state_t;

  state_t            state_r;
  logic [ID_W-1:0]   clr_cnt_r;
  logic [ID_W-1:0]   x_r;
  logic [ID_W-1:0]   b_r;
  logic              sel_b_r;
  logic [ID_W-1:0]   ra_r;
  logic [ID_W-1:0]   rb_r;
  logic [ID_W-1:0]   keep_r;
  logic [WGT_W-1:0]  w_r;
  logic [SIZE_W-1:0] sz_a_r;
  logic [THR_W-1:0]  thr_a_r;
  logic              merged_r;
  logic              inner_r;
  logic              kept_r;

  logic              mode_r;
  logic [THR_W-1:0]  k_r;
  logic [SIZE_W-1:0] min_size_r;

  logic              out_valid_r;
  logic              out_merged_r;
  logic              out_inner_r;
  logic              out_kept_r;
  logic [ID_W-1:0]   out_ra_r;
  logic [ID_W-1:0]   out_rb_r;

  logic              par_we;
  logic [ID_W-1:0]   par_waddr;
  logic [ID_W-1:0]   par_wdata;
  logic [ID_W-1:0]   par_raddr;
  logic [ID_W-1:0]   par_rdata;
  logic              sz_we;
  logic [ID_W-1:0]   sz_waddr;
  logic [SIZE_W-1:0] sz_wdata;
  logic [SIZE_W-1:0] sz_rdata;
  logic              th_we;
  logic [ID_W-1:0]   th_waddr;
  logic [THR_W-1:0]  th_wdata;
  logic [THR_W-1:0]  th_rdata;
  logic [ID_W-1:0]   rt_raddr;

  serm_pkg::div_req_t div_req;
  serm_pkg::div_rsp_t div_rsp;

  logic              accept;
  logic              distinct;
  logic              do_union;
  logic              keep_is_a;
  logic [ID_W-1:0]   keep_id;
  logic [ID_W-1:0]   gone_id;
  logic [SIZE_W:0]   sz_sum;
  logic [SIZE_W-1:0] sz_new;
  logic [THR_W:0]    thr_sum;
  logic [THR_W-1:0]  thr_new;
  logic              out_free;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_ready;

  // Decision once both roots and their size and threshold are known
  assign distinct  = (ra_r != rb_r);
  assign keep_is_a = sz_a_r > sz_rdata;
  assign keep_id   = keep_is_a ? ra_r : rb_r;
  assign gone_id   = keep_is_a ? rb_r : ra_r;
  assign sz_sum    = {1'b0, sz_a_r} + {1'b0, sz_rdata};

  always_comb begin
    if (mode_r == 1'b0) begin
      do_union = distinct && ({8'd0, w_r} <= thr_a_r) && ({8'd0, w_r} <= th_rdata);
    end else begin
      do_union = distinct && ((sz_a_r < min_size_r) || (sz_rdata < min_size_r));
    end
    if (sz_sum > {1'b0, SIZE_MAX}) begin
      sz_new = SIZE_MAX;
    end else if (sz_sum == '0) begin
      sz_new = SIZE_W'(1);
    end else begin
      sz_new = sz_sum[SIZE_W-1:0];
    end
  end

  assign thr_sum = {9'd0, w_r} + {1'b0, div_rsp.quotient};
  assign thr_new = thr_sum[THR_W] ? THR_MAX : thr_sum[THR_W-1:0];

  assign div_req.start    = (state_r == S_EVAL) && do_union;
  assign div_req.dividend = k_r;
  assign div_req.divisor  = sz_new;

  // Memory port steering
  always_comb begin
    par_we    = 1'b0;
    par_waddr = x_r;
    par_wdata = par_rdata;
    par_raddr = x_r;
    sz_we     = 1'b0;
    sz_waddr  = keep_id;
    sz_wdata  = sz_new;
    th_we     = 1'b0;
    th_waddr  = keep_r;
    th_wdata  = thr_new;
    rt_raddr  = ra_r;
    unique case (state_r)
      S_CLEAR: begin
        par_we    = 1'b1;
        par_waddr = clr_cnt_r;
        par_wdata = clr_cnt_r;
        sz_we     = 1'b1;
        sz_waddr  = clr_cnt_r;
        sz_wdata  = SIZE_W'(1);
        th_we     = 1'b1;
        th_waddr  = clr_cnt_r;
        th_wdata  = K_RESET;
      end
      S_IDLE: begin
        par_raddr = in_region_a[ID_W-1:0];
      end
      S_FIND_P: begin
        par_raddr = (par_rdata == x_r) ? b_r : par_rdata;
      end
      S_FIND_G: begin
        // halve: point x at its grandparent and move on to it
        par_we    = 1'b1;
        par_waddr = x_r;
        par_wdata = par_rdata;
        par_raddr = par_rdata;
      end
      S_RD_A: begin
        rt_raddr = ra_r;
      end
      S_RD_B: begin
        rt_raddr = rb_r;
      end
      S_EVAL: begin
        if (do_union) begin
          par_we    = 1'b1;
          par_waddr = gone_id;
          par_wdata = keep_id;
          sz_we     = 1'b1;
        end
      end
      S_DIV: begin
        th_we = div_rsp.done;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= 1'b0;
      k_r        <= K_RESET;
      min_size_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_PASS_MODE) begin
        mode_r <= cfg_wdata[0];
      end
      if (cfg_index == CFG_MERGE_K) begin
        k_r <= cfg_wdata;
      end
      if (cfg_index == CFG_MIN_SIZE) begin
        min_size_r <= cfg_wdata[SIZE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // S_DONE loads or holds the output register itself
      if (out_valid_r && out_ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == ID_W'(NUM_REGIONS - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            x_r     <= in_region_a[ID_W-1:0];
            b_r     <= in_region_b[ID_W-1:0];
            w_r     <= in_edge_weight;
            sel_b_r <= 1'b0;
            state_r <= S_FIND_P;
          end
        end
        S_FIND_P: begin
          if (par_rdata == x_r) begin
            if (!sel_b_r) begin
              ra_r    <= x_r;
              x_r     <= b_r;
              sel_b_r <= 1'b1;
            end else begin
              rb_r    <= x_r;
              state_r <= S_RD_A;
            end
          end else begin
            state_r <= S_FIND_G;
          end
        end
        S_FIND_G: begin
          x_r     <= par_rdata;
          state_r <= S_FIND_P;
        end
        S_RD_A: begin
          state_r <= S_RD_B;
        end
        S_RD_B: begin
          sz_a_r  <= sz_rdata;
          thr_a_r <= th_rdata;
          state_r <= S_EVAL;
        end
        S_EVAL: begin
          merged_r <= do_union;
          inner_r  <= (mode_r == 1'b0) && (do_union || !distinct);
          kept_r   <= (mode_r == 1'b1) && distinct && !do_union;
          keep_r   <= keep_id;
          state_r  <= do_union ? S_DIV : S_DONE;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_merged_r <= merged_r;
            out_inner_r  <= inner_r;
            out_kept_r   <= kept_r;
            out_ra_r     <= ra_r;
            out_rb_r     <= rb_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  serm_ram #(.WIDTH(ID_W), .DEPTH(NUM_REGIONS)) u_parent_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (par_waddr),
    .wdata (par_wdata),
    .raddr (par_raddr),
    .rdata (par_rdata)
  );

  serm_ram #(.WIDTH(SIZE_W), .DEPTH(NUM_REGIONS)) u_size_ram (
    .clk   (clk),
    .we    (sz_we),
    .waddr (sz_waddr),
    .wdata (sz_wdata),
    .raddr (rt_raddr),
    .rdata (sz_rdata)
  );

  serm_ram #(.WIDTH(THR_W), .DEPTH(NUM_REGIONS)) u_thr_ram (
    .clk   (clk),
    .we    (th_we),
    .waddr (th_waddr),
    .wdata (th_wdata),
    .raddr (rt_raddr),
    .rdata (th_rdata)
  );

  serm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign out_valid      = out_valid_r;
  assign out_merged     = out_merged_r;
  assign out_inner_edge = out_inner_r;
  assign out_kept_edge  = out_kept_r;
  assign out_root_a     = REGION_W'(out_ra_r);
  assign out_root_b     = REGION_W'(out_rb_r);

  `SERM_ASSERT_NEXT(a_accept_starts_find, accept, state_r == S_FIND_P, "item did not start a find")
  `SERM_ASSERT_NOW(a_div_done_in_div, div_rsp.done, state_r == S_DIV, "divider done outside wait")
  `SERM_ASSERT_NOW(a_flags_exclusive, out_valid_r, !(out_merged_r && out_kept_r), "merged and kept")
  `SERM_ASSERT_NOW(a_kept_distinct, out_valid_r && out_kept_r, out_ra_r != out_rb_r, "kept same root")
  `SERM_ASSERT_NOW(a_union_distinct, div_req.start, ra_r != rb_r, "union of one root")

endmodule

// ===== design/serm_ram.sv =====
// ---------------------------------------------------------------------------
// serm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module serm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/serm_div.sv =====
// ---------------------------------------------------------------------------
// serm_div
// Restoring divider, one quotient bit per cycle: k / size.
// ---------------------------------------------------------------------------
module serm_div (
  input  logic               clk,
  input  logic               rst_n,
  input  serm_pkg::div_req_t req,
  output serm_pkg::div_rsp_t rsp
);
  import serm_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [SIZE_W-1:0]    rem_r;
  logic [SIZE_W-1:0]    dvs_r;
  logic [THR_W-1:0]     dq_r;
  logic [SIZE_W:0]      rem_sh;
  logic                 ge;
  logic [SIZE_W:0]      rem_sub;

  assign rem_sh  = {rem_r, dq_r[THR_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(THR_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Dividend shifts out the top while quotient bits shift in at the bottom
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      dvs_r <= req.divisor;
      dq_r  <= req.dividend;
    end else if (busy_r) begin
      rem_r <= ge ? rem_sub[SIZE_W-1:0] : rem_sh[SIZE_W-1:0];
      dq_r  <= {dq_r[THR_W-2:0], ge};
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = dq_r;

endmodule
